/* hdl/lcdnum_pkg.sv */
// Shared types and constants of the LCD number display sequencer.
// Used by the register block, the controller, the datapath, the top level and the checker.
package lcdnum_pkg;

  localparam int unsigned COLUMNS     = 16;
  localparam int unsigned CLEAR_BEATS = 2 * (COLUMNS + 1);
  localparam int unsigned CNT_W       = $clog2(CLEAR_BEATS);
  localparam int unsigned INIT_BEATS  = 4;
  localparam int unsigned DEC_DIGITS  = 5;
  localparam int unsigned VAL_W       = 17;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUO_W       = VAL_W - 3;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] REG_ENTRY_MODE      = 2'd2;

  localparam logic [7:0] RST_FUNCTION_SET    = 8'h38;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LINE2_OFFSET  = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_A        = 8'h41;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  // floor(x * RECIP_TEN / 2^RECIP_SHIFT) equals x / 10 for every 17-bit x
  localparam logic [15:0] RECIP_TEN = 16'd52429;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CHAR  = 3'd1,
    OP_UDEC  = 3'd2,
    OP_SDEC  = 3'd3,
    OP_HEX   = 3'd4,
    OP_BIN   = 3'd5,
    OP_CLEAR = 3'd6
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CONV,
    S_INIT,
    S_CURSOR,
    S_CHAR,
    S_SIGN,
    S_DIGITS,
    S_CLEAR
  } state_e;

  typedef enum logic [2:0] {
    BEAT_INIT,
    BEAT_CURSOR,
    BEAT_CHAR,
    BEAT_SIGN,
    BEAT_DIGIT,
    BEAT_CLEAR
  } beat_e;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] entry_mode;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  conv_step;
    logic  cnt_inc;
    logic  emit;
    beat_e kind;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       line_ok;
    logic       dig_zero;
    logic       dig_one;
    logic       init_done;
    logic       clear_done;
    logic       conv_done;
    logic       emit_ok;
  } dp_status_t;

endpackage

/* hdl/lcdnum_regs.sv */
// Configuration registers of the LCD number display sequencer: APB-style write
// and read of the three init commands. Depends on lcdnum_pkg.
module lcdnum_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcdnum_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcdnum_pkg::DATA_W-1:0]  pwdata,
  output logic [lcdnum_pkg::DATA_W-1:0]  prdata,
  output logic                           pready,
  output lcdnum_pkg::cfg_t               cfg_o
);

  logic [7:0] function_set_q, display_control_q, entry_mode_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      function_set_q    <= lcdnum_pkg::RST_FUNCTION_SET;
      display_control_q <= lcdnum_pkg::RST_DISPLAY_CONTROL;
      entry_mode_q      <= lcdnum_pkg::RST_ENTRY_MODE;
    end else if (wr_en) begin
      unique case (reg_idx)
        lcdnum_pkg::REG_FUNCTION_SET:    function_set_q    <= pwdata[7:0];
        lcdnum_pkg::REG_DISPLAY_CONTROL: display_control_q <= pwdata[7:0];
        lcdnum_pkg::REG_ENTRY_MODE:      entry_mode_q      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lcdnum_pkg::REG_FUNCTION_SET:    prdata = {24'd0, function_set_q};
      lcdnum_pkg::REG_DISPLAY_CONTROL: prdata = {24'd0, display_control_q};
      lcdnum_pkg::REG_ENTRY_MODE:      prdata = {24'd0, entry_mode_q};
      default:                         prdata = '0;
    endcase
  end

  assign cfg_o.function_set    = function_set_q;
  assign cfg_o.display_control = display_control_q;
  assign cfg_o.entry_mode      = entry_mode_q;

endmodule

/* hdl/lcdnum_ctrl.sv */
// Controller of the LCD number display sequencer: walks the beats of one
// request and commands the datapath. Depends on lcdnum_pkg.
module lcdnum_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   busy_o,
  input  lcdnum_pkg::dp_status_t status_i,
  output lcdnum_pkg::ctrl_cmd_t  cmd_o
);

  lcdnum_pkg::state_e state_q, state_d;
  lcdnum_pkg::state_e body_state, entry_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdnum_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // What follows the cursor command, or stands first when the line is invalid
  always_comb begin
    unique case (status_i.op) inside
      lcdnum_pkg::OP_CHAR: body_state = lcdnum_pkg::S_CHAR;
      lcdnum_pkg::OP_SDEC: body_state = lcdnum_pkg::S_SIGN;
      lcdnum_pkg::OP_UDEC, lcdnum_pkg::OP_HEX, lcdnum_pkg::OP_BIN: begin
        body_state = status_i.dig_zero ? lcdnum_pkg::S_IDLE : lcdnum_pkg::S_DIGITS;
      end
      default: body_state = lcdnum_pkg::S_IDLE;
    endcase
    entry_state = status_i.line_ok ? lcdnum_pkg::S_CURSOR : body_state;
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.conv_step = 1'b0;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.kind      = lcdnum_pkg::BEAT_INIT;
    cmd_o.last      = 1'b0;
    busy_o          = (state_q != lcdnum_pkg::S_IDLE);

    unique case (state_q)
      lcdnum_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lcdnum_pkg::S_LOAD;
        end
      end
      lcdnum_pkg::S_LOAD: begin
        // the unused opcode drops the request without a beat
        unique case (status_i.op) inside
          lcdnum_pkg::OP_INIT:                      state_d = lcdnum_pkg::S_INIT;
          lcdnum_pkg::OP_CLEAR:                     state_d = lcdnum_pkg::S_CLEAR;
          lcdnum_pkg::OP_UDEC, lcdnum_pkg::OP_SDEC: state_d = lcdnum_pkg::S_CONV;
          lcdnum_pkg::OP_CHAR, lcdnum_pkg::OP_HEX, lcdnum_pkg::OP_BIN: begin
            state_d = entry_state;
          end
          default:                                  state_d = lcdnum_pkg::S_IDLE;
        endcase
      end
      lcdnum_pkg::S_CONV: begin
        cmd_o.conv_step = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (status_i.conv_done) begin
          state_d = entry_state;
        end
      end
      lcdnum_pkg::S_INIT: begin
        cmd_o.kind    = lcdnum_pkg::BEAT_INIT;
        cmd_o.last    = status_i.init_done;
        cmd_o.emit    = status_i.emit_ok;
        cmd_o.cnt_inc = status_i.emit_ok;
        if (status_i.emit_ok && status_i.init_done) begin
          state_d = lcdnum_pkg::S_IDLE;
        end
      end
      lcdnum_pkg::S_CURSOR: begin
        cmd_o.kind = lcdnum_pkg::BEAT_CURSOR;
        cmd_o.last = (body_state == lcdnum_pkg::S_IDLE);
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) begin
          state_d = body_state;
        end
      end
      lcdnum_pkg::S_CHAR: begin
        cmd_o.kind = lcdnum_pkg::BEAT_CHAR;
        cmd_o.last = 1'b1;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) begin
          state_d = lcdnum_pkg::S_IDLE;
        end
      end
      lcdnum_pkg::S_SIGN: begin
        cmd_o.kind = lcdnum_pkg::BEAT_SIGN;
        cmd_o.last = status_i.dig_zero;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok) begin
          state_d = status_i.dig_zero ? lcdnum_pkg::S_IDLE : lcdnum_pkg::S_DIGITS;
        end
      end
      lcdnum_pkg::S_DIGITS: begin
        cmd_o.kind = lcdnum_pkg::BEAT_DIGIT;
        cmd_o.last = status_i.dig_one;
        cmd_o.emit = status_i.emit_ok;
        if (status_i.emit_ok && status_i.dig_one) begin
          state_d = lcdnum_pkg::S_IDLE;
        end
      end
      lcdnum_pkg::S_CLEAR: begin
        cmd_o.kind    = lcdnum_pkg::BEAT_CLEAR;
        cmd_o.last    = status_i.clear_done;
        cmd_o.emit    = status_i.emit_ok;
        cmd_o.cnt_inc = status_i.emit_ok;
        if (status_i.emit_ok && status_i.clear_done) begin
          state_d = lcdnum_pkg::S_IDLE;
        end
      end
      default: state_d = lcdnum_pkg::S_IDLE;
    endcase
  end

endmodule

/* hdl/lcdnum_dp.sv */
// Datapath of the LCD number display sequencer: request registers, decimal
// conversion by reciprocal multiply, beat formatting and output register.
// Depends on lcdnum_pkg.
module lcdnum_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcdnum_pkg::cfg_t       cfg_i,
  input  lcdnum_pkg::ctrl_cmd_t  cmd_i,
  output lcdnum_pkg::dp_status_t status_o,
  input  logic [2:0]             opcode_i,
  input  logic [1:0]             line_i,
  input  logic [4:0]             column_i,
  input  logic [15:0]            number_i,
  input  logic [7:0]             char_code_i,
  input  logic [4:0]             digit_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_data_o,
  output logic [7:0]             bus_byte_o,
  output logic                   last_o
);

  localparam logic [lcdnum_pkg::CNT_W-1:0] InitEnd  =
    lcdnum_pkg::CNT_W'(lcdnum_pkg::INIT_BEATS - 1);
  localparam logic [lcdnum_pkg::CNT_W-1:0] ClearEnd =
    lcdnum_pkg::CNT_W'(lcdnum_pkg::CLEAR_BEATS - 1);
  localparam logic [lcdnum_pkg::CNT_W-1:0] ConvEnd  =
    lcdnum_pkg::CNT_W'(lcdnum_pkg::DEC_DIGITS - 1);
  localparam logic [lcdnum_pkg::CNT_W-1:0] Line2Pos =
    lcdnum_pkg::CNT_W'(lcdnum_pkg::COLUMNS + 1);
  localparam logic [7:0] HexOffset = lcdnum_pkg::CHAR_A - 8'd10;

  logic [2:0]                   op_q;
  logic [1:0]                   line_q;
  logic [4:0]                   col_q;
  logic [15:0]                  num_q;
  logic [7:0]                   ch_q;
  logic [4:0]                   dig_q;
  logic [lcdnum_pkg::CNT_W-1:0] cnt_q;
  logic [lcdnum_pkg::VAL_W-1:0] val_q;
  logic [19:0]                  bcd_q;
  logic                         out_valid_q, is_data_q, last_q;
  logic [7:0]                   byte_q;

  logic [lcdnum_pkg::VAL_W-1:0] load_val;
  logic [32:0]                  prod;
  logic [lcdnum_pkg::QUO_W-1:0] quo;
  logic [lcdnum_pkg::VAL_W-1:0] rem;
  logic [4:0]                   pos;
  logic [3:0]                   digit;
  logic [7:0]                   digit_char, cursor_byte;
  logic                         beat_is_data;
  logic [7:0]                   beat_byte;
  logic                         emit_ok;

  assign load_val = (opcode_i == lcdnum_pkg::OP_SDEC && number_i[15]) ?
                    (lcdnum_pkg::VAL_W'(17'h10000) - {1'b0, number_i}) : {1'b0, number_i};

  assign prod = {16'd0, val_q} * {17'd0, lcdnum_pkg::RECIP_TEN};
  assign quo  = prod[lcdnum_pkg::RECIP_SHIFT +: lcdnum_pkg::QUO_W];
  assign rem  = val_q - {quo, 3'b000} - {2'b00, quo, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      line_q <= line_i;
      col_q  <= column_i;
      num_q  <= number_i;
      ch_q   <= char_code_i;
      dig_q  <= digit_count_i;
      cnt_q  <= '0;
      val_q  <= load_val;
      bcd_q  <= {4'd0, number_i};
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // shift one decimal digit in from the top, least significant first
      if (cmd_i.conv_step) begin
        val_q <= {3'b000, quo};
        bcd_q <= {rem[3:0], bcd_q[19:4]};
      end
      if (cmd_i.emit && cmd_i.kind == lcdnum_pkg::BEAT_DIGIT) begin
        dig_q <= dig_q - 1'b1;
      end
    end
  end

  // Digit at position dig_q-1; positions past the value read as zero
  always_comb begin
    pos = dig_q - 1'b1;
    if (op_q == lcdnum_pkg::OP_BIN) begin
      digit = {3'b000, (pos[4] == 1'b0) ? num_q[pos[3:0]] : 1'b0};
    end else begin
      case (pos)
        5'd0:    digit = bcd_q[3:0];
        5'd1:    digit = bcd_q[7:4];
        5'd2:    digit = bcd_q[11:8];
        5'd3:    digit = bcd_q[15:12];
        5'd4:    digit = bcd_q[19:16];
        default: digit = 4'd0;
      endcase
    end
    digit_char = (digit < 4'd10) ? (lcdnum_pkg::CHAR_ZERO + {4'd0, digit})
                                 : (HexOffset + {4'd0, digit});
    cursor_byte = lcdnum_pkg::CMD_SET_DDRAM |
                  ({3'b000, col_q} - 8'd1 +
                   ((line_q == lcdnum_pkg::LINE_TWO) ? lcdnum_pkg::LINE2_OFFSET : 8'h00));
  end

  always_comb begin
    beat_is_data = 1'b1;
    beat_byte    = lcdnum_pkg::CHAR_SPACE;
    unique case (cmd_i.kind)
      lcdnum_pkg::BEAT_INIT: begin
        beat_is_data = 1'b0;
        case (cnt_q[1:0])
          2'd0:    beat_byte = cfg_i.function_set;
          2'd1:    beat_byte = cfg_i.display_control;
          2'd2:    beat_byte = cfg_i.entry_mode;
          default: beat_byte = lcdnum_pkg::CMD_CLEAR;
        endcase
      end
      lcdnum_pkg::BEAT_CURSOR: begin
        beat_is_data = 1'b0;
        beat_byte    = cursor_byte;
      end
      lcdnum_pkg::BEAT_CHAR: beat_byte = ch_q;
      lcdnum_pkg::BEAT_SIGN: begin
        beat_byte = num_q[15] ? lcdnum_pkg::CHAR_MINUS : lcdnum_pkg::CHAR_PLUS;
      end
      lcdnum_pkg::BEAT_DIGIT: beat_byte = digit_char;
      lcdnum_pkg::BEAT_CLEAR: begin
        if (cnt_q == '0) begin
          beat_is_data = 1'b0;
          beat_byte    = lcdnum_pkg::CMD_SET_DDRAM;
        end else if (cnt_q == Line2Pos) begin
          beat_is_data = 1'b0;
          beat_byte    = lcdnum_pkg::CMD_SET_DDRAM | lcdnum_pkg::LINE2_OFFSET;
        end
      end
      default: ;
    endcase
  end

  assign emit_ok = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      is_data_q <= beat_is_data;
      byte_q    <= beat_byte;
      last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = byte_q;
  assign last_o      = last_q;

  assign status_o.op         = op_q;
  assign status_o.line_ok    = (line_q == lcdnum_pkg::LINE_ONE) ||
                               (line_q == lcdnum_pkg::LINE_TWO);
  assign status_o.dig_zero   = (dig_q == 5'd0);
  assign status_o.dig_one    = (dig_q == 5'd1);
  assign status_o.init_done  = (cnt_q == InitEnd);
  assign status_o.clear_done = (cnt_q == ClearEnd);
  assign status_o.conv_done  = (cnt_q == ConvEnd);
  assign status_o.emit_ok    = emit_ok;

endmodule

/* hdl/lcd_number_display_sequencer_unit.sv */
// An accepted request is loaded into the request registers, decoded in S_LOAD and
// sent beat by beat through the output register (the decimal opcodes first run a
// 5-step divide-by-ten loop). Throughput: one bus write per cycle while the output
// is not stalled; the input stalls until the last beat of a request is emitted.
// Reset: asynchronous, active low; config registers return to 0x38/0x0C/0x06.
// Top level; depends on lcdnum_pkg, lcdnum_regs, lcdnum_ctrl and lcdnum_dp.
module lcd_number_display_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     opcode_i,
  input  logic [1:0]                     line_i,
  input  logic [4:0]                     column_i,
  input  logic [15:0]                    number_i,
  input  logic [7:0]                     char_code_i,
  input  logic [4:0]                     digit_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           is_data_o,
  output logic [7:0]                     bus_byte_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcdnum_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcdnum_pkg::DATA_W-1:0]  pwdata,
  output logic [lcdnum_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);

  lcdnum_pkg::cfg_t       cfg;
  lcdnum_pkg::ctrl_cmd_t  cmd;
  lcdnum_pkg::dp_status_t status;
  logic                   busy;

  assign in_stall_o = busy;

  lcdnum_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdnum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcdnum_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .line_i        (line_i),
    .column_i      (column_i),
    .number_i      (number_i),
    .char_code_i   (char_code_i),
    .digit_count_i (digit_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_data_o     (is_data_o),
    .bus_byte_o    (bus_byte_o),
    .last_o        (last_o)
  );

endmodule

/* hdl/lcdnum_checker.sv */
// Port-level checks of the LCD number display sequencer, bound to the top level.
// Depends on lcdnum_pkg for the bus widths.
module lcdnum_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          is_data_o,
  input logic [7:0]                    bus_byte_o,
  input logic                          last_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [lcdnum_pkg::ADDR_W-1:0] paddr,
  input logic [lcdnum_pkg::DATA_W-1:0] pwdata,
  input logic [lcdnum_pkg::DATA_W-1:0] prdata
);

  // hold a stalled beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(bus_byte_o) && $stable(is_data_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // one request at a time: the cycle after a request is taken, input stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // a written register reads back its low byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[3:2] != 2'd3 |=>
      (paddr != $past(paddr)) || (prdata[7:0] == $past(pwdata[7:0])))
    else $error("config register readback mismatch");

  // registers are eight bits wide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> prdata[31:8] == 24'd0)
    else $error("config readback has stray upper bits");

endmodule

bind lcd_number_display_sequencer_unit lcdnum_checker u_lcdnum_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .is_data_o   (is_data_o),
  .bus_byte_o  (bus_byte_o),
  .last_o      (last_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
